FILE: rtl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types, codes and helpers for the stepper position follower.
// ----------------------------------------------------------------------------
package spf_pkg;

	localparam int POS_BITS = 20;
	localparam int ALARM_BITS = 10;

	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_SET_GOAL = 3'd1;
	localparam logic [2:0] OP_ADD_TRIM = 3'd2;
	localparam logic [2:0] OP_HOME = 3'd3;
	localparam logic [2:0] OP_REZERO = 3'd4;

	localparam logic [1:0] HOME_IDLE = 2'd0;
	localparam logic [1:0] HOME_LEFT = 2'd1;
	localparam logic [1:0] HOME_RIGHT = 2'd2;

	localparam logic [1:0] CFG_STEPS = 2'd0;
	localparam logic [1:0] CFG_OFFSET = 2'd1;
	localparam logic [1:0] CFG_PERIOD = 2'd2;

	typedef struct packed {
		logic [2:0] operation;
		logic signed [15:0] angle_q8;
		logic left_switch_n;
		logic right_switch_n;
		logic [ALARM_BITS-1:0] alarm_samples;
	} in_item_t;

	typedef struct packed {
		logic step_pulse;
		logic direction;
		logic signed [POS_BITS-1:0] position;
		logic signed [POS_BITS-1:0] goal;
		logic signed [POS_BITS-1:0] left_limit;
		logic signed [POS_BITS-1:0] right_limit;
		logic [1:0] homing;
		logic alarm;
		logic signed [POS_BITS-1:0] rezero_offset;
		logic rezero_valid;
	} out_item_t;

	typedef struct packed {
		logic [2:0] op;
		logic signed [15:0] angle;
		logic at_left;
		logic at_right;
		logic all_low;
		logic all_high;
	} cmd_t;

	function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [POS_BITS+1:0] v);
		logic signed [POS_BITS+1:0] hi;
		logic signed [POS_BITS+1:0] lo;
		hi = (POS_BITS+2)'($signed({1'b0, {(POS_BITS-1){1'b1}}}));
		lo = -hi - (POS_BITS+2)'(1);
		if (v > hi) begin
			return hi[POS_BITS-1:0];
		end else if (v < lo) begin
			return lo[POS_BITS-1:0];
		end
		return v[POS_BITS-1:0];
	endfunction

	function automatic logic dir_update(input logic signed [POS_BITS-1:0] g,
		input logic signed [POS_BITS-1:0] p, input logic d);
		if (g > p) begin
			return 1'b0;
		end else if (g < p) begin
			return 1'b1;
		end
		return d;
	endfunction

endpackage

FILE: rtl/spf_front.sv
// ----------------------------------------------------------------------------
// spf_front
// Accepts items, decodes switches and alarm samples, and queues them.
// ----------------------------------------------------------------------------
module spf_front import spf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_item,
	output logic cmd_valid,
	input logic cmd_pop,
	output cmd_t cmd
);

	cmd_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	cmd_t cls;
	logic push;
	logic pop;

	always_comb begin
		cls.op = in_item.operation;
		cls.angle = in_item.angle_q8;
		cls.at_left = ~in_item.left_switch_n;
		cls.at_right = ~in_item.right_switch_n;
		cls.all_low = (in_item.alarm_samples == '0);
		cls.all_high = (in_item.alarm_samples == '1);
	end

	assign in_ready = (count_q != 2'd2);
	assign push = in_valid && in_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign pop = cmd_pop && cmd_valid;
	assign cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: rtl/spf_back.sv
// ----------------------------------------------------------------------------
// spf_back
// Executes queued items against the motion state and registers the result.
// ----------------------------------------------------------------------------
module spf_back import spf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_pop,
	input cmd_t cmd,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [POS_BITS-1:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_item
);

	logic [15:0] steps_q;
	logic signed [POS_BITS-1:0] offset_q;
	logic [15:0] period_q;

	logic signed [POS_BITS-1:0] pos_q, goal_q, lft_q, rgt_q;
	logic signed [15:0] trim_q;
	logic [1:0] hstate_q;
	logic [15:0] hcount_q;
	logic dir_q;
	logic level_q;
	logic latch_q;
	logic out_valid_q;
	out_item_t out_q;

	logic signed [POS_BITS-1:0] pos, goal, lft, rgt, rzoff;
	logic signed [15:0] trim;
	logic signed [16:0] trim_sum;
	logic [1:0] hstate;
	logic [15:0] hcount;
	logic [15:0] period_eff;
	logic dir, pulse, rzv, level, latch;
	logic signed [16:0] mul_in;
	logic signed [33:0] prod;
	logic [33:0] mag;
	logic signed [POS_BITS-1:0] steps;
	logic signed [POS_BITS-1:0] goal_mul;

	assign cmd_pop = cmd_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	always_comb begin
		mul_in = (cmd.op == OP_SET_GOAL) ? (17'(cmd.angle) + 17'(trim_q)) : 17'(trim_q);
		prod = $signed({18'd0, steps_q}) * 34'(mul_in);
		mag = prod[33] ? 34'(-prod) : 34'(prod);
		steps = $signed(POS_BITS'(mag[32:16]));
		goal_mul = prod[33] ? -steps : steps;
	end

	always_comb begin
		pos = pos_q;
		goal = goal_q;
		lft = lft_q;
		rgt = rgt_q;
		trim = trim_q;
		hstate = hstate_q;
		hcount = hcount_q;
		dir = dir_q;
		pulse = 1'b0;
		rzv = 1'b0;
		rzoff = '0;
		period_eff = (period_q == 16'd0) ? 16'd1 : period_q;
		trim_sum = 17'(trim_q) + 17'(cmd.angle);
		level = cmd.all_low ? 1'b0 : (cmd.all_high ? 1'b1 : level_q);
		latch = latch_q | ~level;
		case (cmd.op)
			OP_TICK: begin
				if (hstate_q != HOME_IDLE) begin
					hcount = hcount_q + 16'd1;
					if (hcount >= period_eff) begin
						hcount = 16'd0;
						if (hstate == HOME_LEFT) begin
							if (!cmd.at_left) begin
								goal = sat_pos((POS_BITS+2)'(goal) + (POS_BITS+2)'(1));
								dir = dir_update(goal, pos, dir);
							end else begin
								lft = goal;
								hstate = HOME_RIGHT;
							end
						end
						if (hstate == HOME_RIGHT) begin
							if (!cmd.at_right) begin
								goal = sat_pos((POS_BITS+2)'(goal) - (POS_BITS+2)'(1));
								dir = dir_update(goal, pos, dir);
							end else begin
								rgt = goal;
								pos = sat_pos((POS_BITS+2)'(pos) - (POS_BITS+2)'(offset_q));
								lft = sat_pos((POS_BITS+2)'(lft) - (POS_BITS+2)'(offset_q));
								rgt = sat_pos((POS_BITS+2)'(rgt) - (POS_BITS+2)'(offset_q));
								goal = goal_mul;
								dir = dir_update(goal, pos, dir);
								hstate = HOME_IDLE;
							end
						end
					end
				end
				if (pos < goal) begin
					if (!cmd.at_left) begin
						pos = pos + POS_BITS'(1);
						pulse = 1'b1;
					end
				end else if (pos > goal) begin
					if (!cmd.at_right) begin
						pos = pos - POS_BITS'(1);
						pulse = 1'b1;
					end
				end
			end
			OP_SET_GOAL: begin
				if (hstate_q == HOME_IDLE) begin
					goal = goal_mul;
					dir = dir_update(goal, pos, dir);
				end
			end
			OP_ADD_TRIM: begin
				if (trim_sum > 17'sd32767) begin
					trim = 16'sh7FFF;
				end else if (trim_sum < -17'sd32768) begin
					trim = 16'sh8000;
				end else begin
					trim = trim_sum[15:0];
				end
			end
			OP_HOME: begin
				hstate = HOME_LEFT;
				hcount = 16'd0;
				goal = '0;
				dir = dir_update(goal, pos, dir);
			end
			OP_REZERO: begin
				if (hstate_q == HOME_IDLE) begin
					rzoff = pos_q;
					rzv = 1'b1;
					goal = sat_pos((POS_BITS+2)'(goal_q) - (POS_BITS+2)'(pos_q));
					lft = sat_pos((POS_BITS+2)'(lft_q) - (POS_BITS+2)'(pos_q));
					rgt = sat_pos((POS_BITS+2)'(rgt_q) - (POS_BITS+2)'(pos_q));
					pos = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			out_q.step_pulse <= pulse;
			out_q.direction <= dir;
			out_q.position <= pos;
			out_q.goal <= goal;
			out_q.left_limit <= lft;
			out_q.right_limit <= rgt;
			out_q.homing <= hstate;
			out_q.alarm <= latch;
			out_q.rezero_offset <= rzoff;
			out_q.rezero_valid <= rzv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= 16'd256;
			offset_q <= '0;
			period_q <= 16'd20;
			pos_q <= '0;
			goal_q <= '0;
			lft_q <= '0;
			rgt_q <= '0;
			trim_q <= '0;
			hstate_q <= HOME_IDLE;
			hcount_q <= '0;
			dir_q <= 1'b0;
			level_q <= 1'b1;
			latch_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_STEPS: steps_q <= cfg_data[15:0];
					CFG_OFFSET: offset_q <= $signed(cfg_data);
					CFG_PERIOD: period_q <= cfg_data[15:0];
					default: begin
					end
				endcase
			end
			if (cmd_pop) begin
				pos_q <= pos;
				goal_q <= goal;
				lft_q <= lft;
				rgt_q <= rgt;
				trim_q <= trim;
				hstate_q <= hstate;
				hcount_q <= hcount;
				dir_q <= dir;
				level_q <= level;
				latch_q <= latch;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/stepper_position_follower_homing.sv
// Result path: queue, then result register; an item waits in the queue while the output stalls.
// Throughput: one item per cycle unless the output stalls, set by the combinational back end.
// A two-entry queue separates acceptance from execution; the result register frees on out_ready.
// Reset is asynchronous and active low; it clears all motion state and restores register defaults.
// ----------------------------------------------------------------------------
// stepper_position_follower_homing
// Stepper controller that follows a goal position, with homing and rezero.
// ----------------------------------------------------------------------------
module stepper_position_follower_homing import spf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_item,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [POS_BITS-1:0] cfg_data
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	spf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop),
		.cmd(cmd)
	);

	spf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	a_rezero_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.rezero_valid |->
		out_item.position == '0 && out_item.homing == HOME_IDLE && !out_item.step_pulse)
		else $error("rezero result does not show a fresh origin");

	a_rezero_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.rezero_valid |-> out_item.rezero_offset == '0)
		else $error("rezero offset set without rezero");

	a_alarm_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_item.alarm ##1 out_valid |-> out_item.alarm)
		else $error("alarm flag cleared");

endmodule
